// ===== src/tedrq_pkg.sv =====
// Shared types and constants of the two-epoch deferred release queue.
package tedrq_pkg;

  localparam int unsigned HandleW = 32;
  localparam int unsigned MaskW   = 16;

  // Operation codes.
  localparam logic [1:0] OpRegister = 2'd0;
  localparam logic [1:0] OpAdd      = 2'd1;
  localparam logic [1:0] OpTick     = 2'd2;
  localparam logic [1:0] OpFlush    = 2'd3;

  // Result status codes.
  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusFull   = 2'd1;
  localparam logic [1:0] StatusNoSlot = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [HandleW-1:0] item_handle;
    logic [MaskW-1:0]   thread_mask;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [MaskW-1:0]   assigned_mask;
    logic               epoch_advanced;
    logic               released_valid;
    logic [HandleW-1:0] released_handle;
    logic               last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic read;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_drain;
    logic drain_more;
    logic out_free;
  } stat_t;

endpackage

// ===== src/tedrq_ctrl.sv =====
// Controller state machine that sequences operations and bucket drains.
module tedrq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tedrq_pkg::stat_t stat_i,
  output tedrq_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  // New items are taken only when idle and the output slot can take a result.
  assign in_stall_o = !((state_q == StIdle) && stat_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o.exec = 1'b0;
    cmd_o.read = 1'b0;
    cmd_o.emit = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.exec = 1'b1;
          if (stat_i.needs_drain) state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.read = 1'b1;
        state_d    = StEmit;
      end
      StEmit: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = stat_i.drain_more ? StRead : StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/tedrq_datapath.sv =====
// Datapath with bucket memory, counts, thread masks and the output register.
module tedrq_datapath #(
  parameter int unsigned BUCKET_DEPTH = 32,
  parameter int unsigned MAX_THREADS  = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tedrq_pkg::in_t   in_data_i,
  input  tedrq_pkg::cmd_t  cmd_i,
  output tedrq_pkg::stat_t stat_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tedrq_pkg::out_t  out_data_o
);

  localparam int unsigned Depth     = 2 * BUCKET_DEPTH;
  localparam int unsigned AW        = $clog2(Depth);
  localparam int unsigned IW        = $clog2(BUCKET_DEPTH);
  localparam int unsigned CW        = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned SlotLimit = (MAX_THREADS > 16) ? 16 : MAX_THREADS;
  localparam int unsigned MW        = tedrq_pkg::MaskW;
  localparam int unsigned HW        = tedrq_pkg::HandleW;

  logic [HW-1:0]   mem [Depth];
  logic [HW-1:0]   rdata_q;
  logic [CW-1:0]   bcnt0_q, bcnt0_d, bcnt1_q, bcnt1_d;
  logic            cur_q, cur_d;
  logic [4:0]      reg_count_q, reg_count_d;
  logic [MW-1:0]   reg_bits_q, reg_bits_d;
  logic [MW-1:0]   ck_bits_q, ck_bits_d;
  logic            drain_b_q, drain_b_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic            flush_q, flush_d;
  logic            adv_q, adv_d;
  logic            out_valid_q, out_valid_d;
  tedrq_pkg::out_t out_q, out_d;

  logic [MW-1:0] ck_new;
  logic          tick_match;
  logic [CW-1:0] cnt_cur, cnt_other, cnt_drain;
  logic          idx_end;
  logic          drain_more;
  logic          mem_we;
  logic [AW-1:0] waddr, raddr;

  // Derived status of the current state.
  assign ck_new     = ck_bits_q | in_data_i.thread_mask;
  assign tick_match = (ck_new == reg_bits_q);
  assign cnt_cur    = cur_q ? bcnt1_q : bcnt0_q;
  assign cnt_other  = cur_q ? bcnt0_q : bcnt1_q;
  assign cnt_drain  = drain_b_q ? bcnt1_q : bcnt0_q;
  assign idx_end    = ((CW'(idx_q) + CW'(1)) == cnt_drain);
  assign drain_more = !idx_end || (flush_q && !drain_b_q && (bcnt1_q != '0));

  assign waddr = (cur_q ? AW'(BUCKET_DEPTH) : AW'(0)) + AW'(cnt_cur[IW-1:0]);
  assign raddr = (drain_b_q ? AW'(BUCKET_DEPTH) : AW'(0)) + AW'(idx_q);

  assign stat_o.out_free    = !out_valid_q || !out_stall_i;
  assign stat_o.drain_more  = drain_more;
  assign stat_o.needs_drain =
      ((in_data_i.op == tedrq_pkg::OpTick) && tick_match && (cnt_other != '0)) ||
      ((in_data_i.op == tedrq_pkg::OpFlush) && ((bcnt0_q != '0) || (bcnt1_q != '0)));

  // Operation execution and drain stepping.
  always_comb begin
    bcnt0_d     = bcnt0_q;
    bcnt1_d     = bcnt1_q;
    cur_d       = cur_q;
    reg_count_d = reg_count_q;
    reg_bits_d  = reg_bits_q;
    ck_bits_d   = ck_bits_q;
    drain_b_d   = drain_b_q;
    idx_d       = idx_q;
    flush_d     = flush_q;
    adv_d       = adv_q;
    mem_we      = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.exec) begin
      out_d      = '0;
      out_d.last = 1'b1;
      case (in_data_i.op)
        tedrq_pkg::OpRegister: begin
          out_valid_d = 1'b1;
          if (32'(reg_count_q) >= SlotLimit) begin
            out_d.status = tedrq_pkg::StatusNoSlot;
          end else begin
            out_d.assigned_mask = MW'(1) << reg_count_q;
            reg_bits_d          = reg_bits_q | (MW'(1) << reg_count_q);
            reg_count_d         = reg_count_q + 5'd1;
          end
        end
        tedrq_pkg::OpAdd: begin
          out_valid_d = 1'b1;
          if (32'(cnt_cur) >= BUCKET_DEPTH) begin
            out_d.status = tedrq_pkg::StatusFull;
          end else begin
            mem_we = 1'b1;
            if (cur_q) bcnt1_d = bcnt1_q + CW'(1);
            else       bcnt0_d = bcnt0_q + CW'(1);
          end
        end
        tedrq_pkg::OpTick: begin
          if (!tick_match) begin
            ck_bits_d   = ck_new;
            out_valid_d = 1'b1;
          end else begin
            ck_bits_d = '0;
            cur_d     = !cur_q;
            if (cnt_other == '0) begin
              out_d.epoch_advanced = 1'b1;
              out_valid_d          = 1'b1;
            end else begin
              drain_b_d = !cur_q;
              idx_d     = '0;
              flush_d   = 1'b0;
              adv_d     = 1'b1;
            end
          end
        end
        tedrq_pkg::OpFlush: begin
          if ((bcnt0_q == '0) && (bcnt1_q == '0)) begin
            out_valid_d = 1'b1;
          end else begin
            drain_b_d = (bcnt0_q == '0);
            idx_d     = '0;
            flush_d   = 1'b1;
            adv_d     = 1'b0;
          end
        end
        default: out_valid_d = 1'b1;
      endcase
    end

    if (cmd_i.emit) begin
      out_valid_d           = 1'b1;
      out_d.status          = tedrq_pkg::StatusOk;
      out_d.assigned_mask   = '0;
      out_d.epoch_advanced  = adv_q;
      out_d.released_valid  = 1'b1;
      out_d.released_handle = rdata_q;
      out_d.last            = !drain_more;
      if (idx_end) begin
        if (drain_b_q) bcnt1_d = '0;
        else           bcnt0_d = '0;
        drain_b_d = 1'b1;
        idx_d     = '0;
      end else begin
        idx_d = idx_q + IW'(1);
      end
    end
  end

  // Bucket memory: one write port for adds, one registered read port for drains.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= in_data_i.item_handle;
    if (cmd_i.read) rdata_q <= mem[raddr];
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt0_q     <= '0;
      bcnt1_q     <= '0;
      cur_q       <= 1'b0;
      reg_count_q <= '0;
      reg_bits_q  <= '0;
      ck_bits_q   <= '0;
      drain_b_q   <= 1'b0;
      idx_q       <= '0;
      flush_q     <= 1'b0;
      adv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bcnt0_q     <= bcnt0_d;
      bcnt1_q     <= bcnt1_d;
      cur_q       <= cur_d;
      reg_count_q <= reg_count_d;
      reg_bits_q  <= reg_bits_d;
      ck_bits_q   <= ck_bits_d;
      drain_b_q   <= drain_b_d;
      idx_q       <= idx_d;
      flush_q     <= flush_d;
      adv_q       <= adv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A drained result is only loaded when the output slot is free.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> stat_o.out_free)
    else $error("drain result loaded over a pending transfer");

  // Bucket counts never pass the bucket depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(bcnt0_q) <= BUCKET_DEPTH) && (32'(bcnt1_q) <= BUCKET_DEPTH))
    else $error("bucket count beyond depth");

  // The registered mask always holds one bit per registered thread, from bit zero.
  a_reg_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reg_bits_q == MW'((17'(1) << reg_count_q) - 17'(1)))
    else $error("registered mask out of step with thread count");

  // A completed epoch leaves the check-in mask empty.
  a_epoch_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (in_data_i.op == tedrq_pkg::OpTick) && tick_match) |=>
      (ck_bits_q == '0))
    else $error("check-in mask not cleared after epoch advance");

endmodule

// ===== src/two_epoch_deferred_release_queue.sv =====
// Top level of the two-epoch deferred release queue.
//
// Usage: operations enter on the input channel (in_valid_i, in_stall_o,
// in_data_i) and results leave on the output channel (out_valid_o,
// out_stall_i, out_data_o). A transfer happens on a rising edge where valid
// is high and stall is low. Register, add and tick-without-advance items give
// one result, loaded into the output register by the edge of the input transfer;
// such items sustain one per cycle while the receiver keeps up.
// A tick that completes the epoch drains the bucket that becomes current, and
// a flush drains bucket 0 and then bucket 1. Each released handle is first read
// through the registered read port and then loaded into the output register,
// which waits while the output slot is not free. The last result of every
// item carries last. While a drain runs, or while a result waits in the output
// register under out_stall_i, the block raises in_stall_o and takes no new item.
// Reset clears all counts, masks and the current bucket index at once; the
// bucket memory is not cleared, since entries are read only after being written.
module two_epoch_deferred_release_queue #(
  parameter int unsigned BUCKET_DEPTH = 32,
  parameter int unsigned MAX_THREADS  = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tedrq_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tedrq_pkg::out_t out_data_o
);

  tedrq_pkg::cmd_t  cmd;
  tedrq_pkg::stat_t stat;

  // Sequencing of operations and drains.
  tedrq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Storage, masks and result formation.
  tedrq_datapath #(
    .BUCKET_DEPTH (BUCKET_DEPTH),
    .MAX_THREADS  (MAX_THREADS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/tb_two_epoch_deferred_release_queue.sv =====
// Self-checking testbench for the two-epoch deferred release queue.
module tb_two_epoch_deferred_release_queue;
  import tedrq_pkg::*;

  localparam int unsigned BucketDepth   = 32;
  localparam int unsigned SlotLimit     = 16;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 8;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  // Shadow state of the release queue, updated on every accepted transfer.
  logic [HandleW-1:0] shadow_bucket [2][BucketDepth];
  int unsigned        shadow_fill [2];
  logic               shadow_cur;
  int unsigned        shadow_threads;
  logic [MaskW-1:0]   shadow_reg_mask;
  logic [MaskW-1:0]   shadow_checkin_mask;

  // Results still owed by the block, oldest first.
  out_t reclaim_replies [$];

  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int long_hold_cycles = 0;

  int mismatch_count  = 0;
  int ops_sent        = 0;
  int results_checked = 0;
  int epochs_advanced = 0;
  int handles_freed   = 0;
  int idle_cycles     = 0;

  two_epoch_deferred_release_queue #(
    .BUCKET_DEPTH(BucketDepth),
    .MAX_THREADS (SlotLimit)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Clock with a period of four time units.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic out_t make_reply(logic [1:0] status, logic [MaskW-1:0] assigned,
                                      logic adv, logic rel_valid,
                                      logic [HandleW-1:0] handle, logic is_last);
    out_t r;
    r.status          = status;
    r.assigned_mask   = assigned;
    r.epoch_advanced  = adv;
    r.released_valid  = rel_valid;
    r.released_handle = handle;
    r.last            = is_last;
    return r;
  endfunction

  // Applies one operation to the shadow state and queues the results it causes.
  task automatic apply_reclaim_op(input in_t item);
    logic [MaskW-1:0] new_bit;
    int unsigned      total;
    int unsigned      idx;
    case (item.op)
      OpRegister: begin
        if (shadow_threads >= SlotLimit) begin
          reclaim_replies.push_back(make_reply(StatusNoSlot, '0, 1'b0, 1'b0, '0, 1'b1));
        end else begin
          new_bit = MaskW'(1) << shadow_threads;
          shadow_reg_mask |= new_bit;
          shadow_threads++;
          reclaim_replies.push_back(make_reply(StatusOk, new_bit, 1'b0, 1'b0, '0, 1'b1));
        end
      end
      OpAdd: begin
        if (shadow_fill[shadow_cur] >= BucketDepth) begin
          reclaim_replies.push_back(make_reply(StatusFull, '0, 1'b0, 1'b0, '0, 1'b1));
        end else begin
          shadow_bucket[shadow_cur][shadow_fill[shadow_cur]] = item.item_handle;
          shadow_fill[shadow_cur]++;
          reclaim_replies.push_back(make_reply(StatusOk, '0, 1'b0, 1'b0, '0, 1'b1));
        end
      end
      OpTick: begin
        shadow_checkin_mask |= item.thread_mask;
        if (shadow_checkin_mask != shadow_reg_mask) begin
          reclaim_replies.push_back(make_reply(StatusOk, '0, 1'b0, 1'b0, '0, 1'b1));
        end else begin
          // Epoch completes: flip buckets and release the one now current.
          shadow_checkin_mask = '0;
          shadow_cur = ~shadow_cur;
          epochs_advanced++;
          total = shadow_fill[shadow_cur];
          if (total == 0) begin
            reclaim_replies.push_back(make_reply(StatusOk, '0, 1'b1, 1'b0, '0, 1'b1));
          end
          for (idx = 0; idx < total; idx++) begin
            reclaim_replies.push_back(make_reply(StatusOk, '0, 1'b1, 1'b1,
                                                 shadow_bucket[shadow_cur][idx],
                                                 idx == total - 1));
          end
          shadow_fill[shadow_cur] = 0;
        end
      end
      default: begin
        // Flush releases bucket 0 and then bucket 1 without touching the epoch.
        total = shadow_fill[0] + shadow_fill[1];
        if (total == 0) begin
          reclaim_replies.push_back(make_reply(StatusOk, '0, 1'b0, 1'b0, '0, 1'b1));
        end
        for (idx = 0; idx < total; idx++) begin
          if (idx < shadow_fill[0]) begin
            reclaim_replies.push_back(make_reply(StatusOk, '0, 1'b0, 1'b1,
                                                 shadow_bucket[0][idx], idx == total - 1));
          end else begin
            reclaim_replies.push_back(make_reply(StatusOk, '0, 1'b0, 1'b1,
                                                 shadow_bucket[1][idx - shadow_fill[0]],
                                                 idx == total - 1));
          end
        end
        shadow_fill[0] = 0;
        shadow_fill[1] = 0;
      end
    endcase
  endtask

  // Offers one operation and holds it until the block takes the transfer.
  task automatic send_op(input logic [1:0] op, input logic [HandleW-1:0] handle,
                         input logic [MaskW-1:0] mask);
    int gap;
    in_t item;
    gap = tx_idle_en ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item.op          = op;
    item.item_handle = handle;
    item.thread_mask = mask;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    apply_reclaim_op(item);
    ops_sent++;
  endtask

  // Stops offering and waits until every owed result has been seen.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (reclaim_replies.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d field %s got %0h expected %0h",
                                results_checked, name, got, want));
    end
  endtask

  // Tick masks: mostly a thread still missing this epoch, sometimes noise.
  function automatic logic [MaskW-1:0] pick_tick_mask();
    logic [MaskW-1:0] missing;
    int pick;
    int bit_idx;
    missing = shadow_reg_mask & ~shadow_checkin_mask;
    pick = $urandom_range(0, 99);
    if (pick < 60 && missing != '0) begin
      do bit_idx = $urandom_range(0, MaskW - 1); while (!missing[bit_idx]);
      return MaskW'(1) << bit_idx;
    end else if (pick < 85) begin
      return MaskW'(1) << $urandom_range(0, MaskW - 1);
    end
    return MaskW'($urandom);
  endfunction

  // Receiver: random stalls per result, plus a long hold when requested.
  initial begin : drive_out_stall
    int hold;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold_cycles > 0) begin
        hold = long_hold_cycles;
        long_hold_cycles = 0;
      end else begin
        hold = rx_idle_en ? $urandom_range(0, 10) : 0;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare each accepted result with the oldest one owed.
  always @(posedge clk_i) begin : check_replies
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reclaim_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0h with nothing owed", out_data_o));
      end else begin
        want = reclaim_replies.pop_front();
        check_field("status", 32'(out_data_o.status), 32'(want.status));
        check_field("assigned_mask", 32'(out_data_o.assigned_mask),
                    32'(want.assigned_mask));
        check_field("epoch_advanced", 32'(out_data_o.epoch_advanced),
                    32'(want.epoch_advanced));
        check_field("released_valid", 32'(out_data_o.released_valid),
                    32'(want.released_valid));
        check_field("released_handle", out_data_o.released_handle, want.released_handle);
        check_field("last", 32'(out_data_o.last), 32'(want.last));
        if (want.released_valid) handles_freed++;
      end
      results_checked++;
    end
  end

  // Watchdog on stretches with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("two_epoch_deferred_release_queue test failed");
      $finish;
    end
  end

  // Empty drains, flushes, partial registration and an unregistered check-in.
  task automatic test_epoch_basics();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_op(OpAdd, 32'h0000_0000, 16'h0000);
    send_op(OpAdd, 32'hFFFF_FFFF, 16'hFFFF);
    // With no threads registered, a zero check-in completes the epoch.
    send_op(OpTick, 32'h1234_5678, 16'h0000);
    send_op(OpFlush, 32'h0, 16'h0);
    send_op(OpFlush, 32'hFFFF_FFFF, 16'hFFFF);
    send_op(OpRegister, 32'hDEAD_BEEF, 16'hFFFF);
    send_op(OpRegister, 32'h0, 16'h0);
    send_op(OpAdd, 32'hA5A5_5A5A, 16'h0);
    send_op(OpTick, 32'h0, 16'h0001);
    send_op(OpTick, 32'h0, 16'h0002);
    send_op(OpAdd, 32'h5A5A_A5A5, 16'h0);
    send_op(OpTick, 32'h0, 16'h0003);
    // A bit that nobody owns yet blocks the epoch until it is registered.
    send_op(OpTick, 32'h0, 16'h8000);
    wait_for_results();
  endtask

  // Fill every thread slot, overflow once, then complete the blocked epoch.
  task automatic test_thread_registration();
    repeat (SlotLimit - 1) send_op(OpRegister, $urandom, MaskW'($urandom));
    send_op(OpTick, 32'h0, 16'h7FFF);
    wait_for_results();
  endtask

  // Both buckets overfull, then one flush releases the maximum batch.
  task automatic test_bucket_overflow();
    repeat (BucketDepth + 2) send_op(OpAdd, $urandom, MaskW'($urandom));
    send_op(OpTick, $urandom, 16'hFFFF);
    repeat (BucketDepth + 1) send_op(OpAdd, $urandom, MaskW'($urandom));
    send_op(OpFlush, $urandom, MaskW'($urandom));
    wait_for_results();
  endtask

  // Long receiver hold while the sender keeps offering, so the input stalls.
  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    long_hold_cycles = 150;
    repeat (10) send_op(OpAdd, $urandom, MaskW'($urandom));
    send_op(OpTick, $urandom, 16'hFFFF);
    repeat (8) send_op(OpAdd, $urandom, MaskW'($urandom));
    send_op(OpFlush, $urandom, MaskW'($urandom));
    wait_for_results();
  endtask

  task automatic test_random_traffic(input bit tx_idle, input bit rx_idle, input int n_ops);
    int pick;
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    repeat (n_ops) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_op(OpRegister, $urandom, MaskW'($urandom));
      end else if (pick < 50) begin
        send_op(OpAdd, $urandom, MaskW'($urandom));
      end else if (pick < 92) begin
        send_op(OpTick, $urandom, pick_tick_mask());
      end else begin
        send_op(OpFlush, $urandom, MaskW'($urandom));
      end
    end
    wait_for_results();
  endtask

  // Reset once, then run the tests in order.
  initial begin
    shadow_fill[0]      = 0;
    shadow_fill[1]      = 0;
    shadow_cur          = 1'b0;
    shadow_threads      = 0;
    shadow_reg_mask     = '0;
    shadow_checkin_mask = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_epoch_basics();
    test_thread_registration();
    test_bucket_overflow();
    test_output_backpressure();
    test_random_traffic(1'b1, 1'b1, 65);
    test_random_traffic(1'b0, 1'b0, 65);
    test_random_traffic(1'b1, 1'b0, 65);
    test_random_traffic(1'b0, 1'b1, 65);
    $display("Sent %0d operations and checked %0d results.", ops_sent, results_checked);
    $display("Saw %0d epoch advances and %0d released handles; %0d mismatches.",
             epochs_advanced, handles_freed, mismatch_count);
    if (mismatch_count == 0 && reclaim_replies.size() == 0) begin
      $display("two_epoch_deferred_release_queue test passed");
    end else begin
      $display("two_epoch_deferred_release_queue test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tedrq_pkg.sv
src/tedrq_ctrl.sv
src/tedrq_datapath.sv
src/two_epoch_deferred_release_queue.sv
tb/tb_two_epoch_deferred_release_queue.sv
